@@ rtl/iept_pkg.sv @@
// Shared types and constants for the ICMP echo pair tracker.
package iept_pkg;

  localparam int unsigned FLOWS_DEF   = 16;
  localparam int unsigned SLOTS_DEF   = 4;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned FIDX_W      = 4;
  localparam int unsigned EXP_W       = 7;
  localparam int unsigned IN_DATA_W   = 96;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [EXP_W-1:0]     EXP_MAX     = 7'd127;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_REPLY   = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_OTHER   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NEW_FLOW   = 3'd0,
    ST_REQ_ADDED  = 3'd1,
    ST_MATCHED    = 3'd2,
    ST_DENY       = 3'd3,
    ST_MISMATCH   = 3'd4,
    ST_TABLE_FULL = 3'd5,
    ST_SLOTS_FULL = 3'd6,
    ST_IGNORED    = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_F_NEXT,
    OP_F_LATCH,
    OP_NEW_FLOW,
    OP_REQ_ADD,
    OP_FLOW_KEEP,
    OP_K_NEXT,
    OP_D_MOVE,
    OP_D_END,
    OP_W_CHECK,
    OP_W_END,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_S_RD,
    FSM_S_CMP,
    FSM_HIT,
    FSM_K_RD,
    FSM_K_CMP,
    FSM_D_RD,
    FSM_D_WR,
    FSM_W_RD,
    FSM_W_CNT,
    FSM_W_SRD,
    FSM_W_SCHK,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    dp_op_e  op;
    logic    status_we;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    cmd_e in_kind;
    cmd_e kind;
    logic f_end;
    logic table_full;
    logic hit;
    logic slots_full;
    logic k_end;
    logic seq_hit;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/icmp_echo_pair_tracker.sv @@
// Top level of the ICMP echo pair tracker.
// One transaction in gives one transaction out. Requests and replies scan the
// flow table one entry at a time (read, then compare, as the flow RAM read is
// registered); replies then walk the matched flow's slots one at a time. A tick
// sweeps every opened flow and checks each of its pending slots for expiry.
// Input is taken only between transactions; the result register frees the
// input side while a result waits. The user must write timeout_ms through
// cfg_we_i/cfg_wdata_i only while idle; the block itself does not enforce it.
module icmp_echo_pair_tracker #(
  parameter int unsigned FLOWS = iept_pkg::FLOWS_DEF,
  parameter int unsigned SLOTS = iept_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [iept_pkg::TIMEOUT_W-1:0]  cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // src_ip[31:0], dst_ip[63:32], icmp_id[79:64], seq_no[95:80]
  input  logic [iept_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[2:0], flow_index[6:3], expired_count[13:7], zero[15:14]
  output logic [iept_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  iept_pkg::dp_cmd_t  cmd;
  iept_pkg::dp_stat_t stat;

  iept_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  iept_dpath #(.FLOWS(FLOWS), .SLOTS(SLOTS)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

@@ rtl/iept_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module iept_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/iept_ctrl.sv @@
// Controller state machine sequencing flow search, slot updates and tick sweeps.
module iept_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iept_pkg::dp_stat_t stat_i,
  output iept_pkg::dp_cmd_t  cmd_o,
  output logic               in_ready_o
);

  iept_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iept_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = iept_pkg::OP_NONE;
    cmd_o.status_we = 1'b0;
    cmd_o.status    = iept_pkg::ST_IGNORED;
    in_ready_o      = 1'b0;
    unique case (state_q)
      iept_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.op        = iept_pkg::OP_LOAD;
          cmd_o.status_we = 1'b1;
          cmd_o.status    = iept_pkg::ST_IGNORED;
          priority if (stat_i.in_kind == iept_pkg::CMD_TICK) begin
            state_d = iept_pkg::FSM_W_RD;
          end else if (stat_i.in_kind == iept_pkg::CMD_OTHER) begin
            state_d = iept_pkg::FSM_DONE;
          end else begin
            state_d = iept_pkg::FSM_S_RD;
          end
        end
      end
      iept_pkg::FSM_S_RD: begin
        if (stat_i.f_end) begin
          cmd_o.status_we = 1'b1;
          state_d         = iept_pkg::FSM_DONE;
          priority if (stat_i.kind == iept_pkg::CMD_REPLY) begin
            cmd_o.status = iept_pkg::ST_DENY;
          end else if (stat_i.table_full) begin
            cmd_o.status = iept_pkg::ST_TABLE_FULL;
          end else begin
            cmd_o.op     = iept_pkg::OP_NEW_FLOW;
            cmd_o.status = iept_pkg::ST_NEW_FLOW;
          end
        end else begin
          state_d = iept_pkg::FSM_S_CMP;
        end
      end
      iept_pkg::FSM_S_CMP: begin
        if (stat_i.hit) begin
          cmd_o.op = iept_pkg::OP_F_LATCH;
          state_d  = iept_pkg::FSM_HIT;
        end else begin
          cmd_o.op = iept_pkg::OP_F_NEXT;
          state_d  = iept_pkg::FSM_S_RD;
        end
      end
      iept_pkg::FSM_HIT: begin
        priority if (stat_i.kind == iept_pkg::CMD_REPLY) begin
          state_d = iept_pkg::FSM_K_RD;
        end else if (stat_i.slots_full) begin
          cmd_o.op        = iept_pkg::OP_FLOW_KEEP;
          cmd_o.status_we = 1'b1;
          cmd_o.status    = iept_pkg::ST_SLOTS_FULL;
          state_d         = iept_pkg::FSM_DONE;
        end else begin
          cmd_o.op        = iept_pkg::OP_REQ_ADD;
          cmd_o.status_we = 1'b1;
          cmd_o.status    = iept_pkg::ST_REQ_ADDED;
          state_d         = iept_pkg::FSM_DONE;
        end
      end
      iept_pkg::FSM_K_RD: begin
        if (stat_i.k_end) begin
          cmd_o.op        = iept_pkg::OP_FLOW_KEEP;
          cmd_o.status_we = 1'b1;
          cmd_o.status    = iept_pkg::ST_MISMATCH;
          state_d         = iept_pkg::FSM_DONE;
        end else begin
          state_d = iept_pkg::FSM_K_CMP;
        end
      end
      iept_pkg::FSM_K_CMP: begin
        cmd_o.op = iept_pkg::OP_K_NEXT;
        state_d  = stat_i.seq_hit ? iept_pkg::FSM_D_RD : iept_pkg::FSM_K_RD;
      end
      iept_pkg::FSM_D_RD: begin
        if (stat_i.k_end) begin
          cmd_o.op        = iept_pkg::OP_D_END;
          cmd_o.status_we = 1'b1;
          cmd_o.status    = iept_pkg::ST_MATCHED;
          state_d         = iept_pkg::FSM_DONE;
        end else begin
          state_d = iept_pkg::FSM_D_WR;
        end
      end
      iept_pkg::FSM_D_WR: begin
        cmd_o.op = iept_pkg::OP_D_MOVE;
        state_d  = iept_pkg::FSM_D_RD;
      end
      iept_pkg::FSM_W_RD: begin
        state_d = stat_i.f_end ? iept_pkg::FSM_DONE : iept_pkg::FSM_W_CNT;
      end
      iept_pkg::FSM_W_CNT: begin
        cmd_o.op = iept_pkg::OP_F_LATCH;
        state_d  = iept_pkg::FSM_W_SRD;
      end
      iept_pkg::FSM_W_SRD: begin
        if (stat_i.k_end) begin
          cmd_o.op = iept_pkg::OP_W_END;
          state_d  = iept_pkg::FSM_W_RD;
        end else begin
          state_d = iept_pkg::FSM_W_SCHK;
        end
      end
      iept_pkg::FSM_W_SCHK: begin
        cmd_o.op = iept_pkg::OP_W_CHECK;
        state_d  = iept_pkg::FSM_W_SRD;
      end
      iept_pkg::FSM_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = iept_pkg::OP_RESULT;
          state_d  = iept_pkg::FSM_IDLE;
        end
      end
      default: state_d = iept_pkg::FSM_IDLE;
    endcase
  end

endmodule

@@ rtl/iept_dpath.sv @@
// Datapath: flow and slot memories, counters, timeout register and result register.
module iept_dpath #(
  parameter int unsigned FLOWS = iept_pkg::FLOWS_DEF,
  parameter int unsigned SLOTS = iept_pkg::SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iept_pkg::TIMEOUT_W-1:0]      cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic [iept_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [iept_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  iept_pkg::dp_cmd_t                   cmd_i,
  output iept_pkg::dp_stat_t                  stat_o
);

  localparam int unsigned FA  = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int unsigned FCW = $clog2(FLOWS + 1);
  localparam int unsigned SA  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned KW  = 2 * iept_pkg::ADDR_W + iept_pkg::ID_W;
  localparam int unsigned FW  = KW + CW;
  localparam int unsigned SW  = iept_pkg::SEQ_W + iept_pkg::STAMP_W;

  // latched transaction
  iept_pkg::cmd_e                 kind_q;
  logic [iept_pkg::ADDR_W-1:0]    src_q, dst_q;
  logic [iept_pkg::ID_W-1:0]      id_q;
  logic [iept_pkg::SEQ_W-1:0]     seq_q;
  logic [KW-1:0]                  key_q;

  logic [iept_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [iept_pkg::STAMP_W-1:0]   now_q;
  logic [FCW-1:0]                 f_q, fcount_q;
  logic [CW-1:0]                  c_q, k_q, w_q;
  logic [iept_pkg::EXP_W-1:0]     exp_q;
  iept_pkg::status_e              status_q;
  logic                           m_valid_q;
  logic [iept_pkg::OUT_DATA_W-1:0] m_data_q;

  logic              flow_we;
  logic [FW-1:0]     flow_wdata, flow_rdata;
  logic              slot_we;
  logic [CW-1:0]     slot_widx;
  logic [SW-1:0]     slot_wdata, slot_rdata;

  logic [iept_pkg::ADDR_W-1:0]  rd_snd, rd_dst;
  logic [iept_pkg::ID_W-1:0]    rd_id;
  logic [CW-1:0]                rd_cnt;
  logic [iept_pkg::SEQ_W-1:0]   rd_seq;
  logic [iept_pkg::STAMP_W-1:0] rd_stamp, age;
  logic                         expired;
  logic [KW-1:0]                in_key;
  logic [iept_pkg::FIDX_W-1:0]  res_flow;

  assign rd_snd   = flow_rdata[iept_pkg::ADDR_W-1:0];
  assign rd_dst   = flow_rdata[2*iept_pkg::ADDR_W-1:iept_pkg::ADDR_W];
  assign rd_id    = flow_rdata[KW-1:2*iept_pkg::ADDR_W];
  assign rd_cnt   = flow_rdata[FW-1:KW];
  assign rd_seq   = slot_rdata[iept_pkg::SEQ_W-1:0];
  assign rd_stamp = slot_rdata[SW-1:iept_pkg::SEQ_W];
  assign age      = now_q - rd_stamp;
  assign expired  = age >= {{(iept_pkg::STAMP_W-iept_pkg::TIMEOUT_W){1'b0}}, timeout_q};
  assign in_key   = {id_q, dst_q, src_q};

  iept_ram #(.WIDTH(FW), .ADDR_W(FA)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (flow_we),
    .waddr_i (f_q[FA-1:0]),
    .wdata_i (flow_wdata),
    .raddr_i (f_q[FA-1:0]),
    .rdata_o (flow_rdata)
  );

  iept_ram #(.WIDTH(SW), .ADDR_W(FA + SA)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i ({f_q[FA-1:0], slot_widx[SA-1:0]}),
    .wdata_i (slot_wdata),
    .raddr_i ({f_q[FA-1:0], k_q[SA-1:0]}),
    .rdata_o (slot_rdata)
  );

  always_comb begin
    flow_we    = 1'b0;
    flow_wdata = {c_q, in_key};
    slot_we    = 1'b0;
    slot_widx  = k_q;
    slot_wdata = {now_q, seq_q};
    unique case (cmd_i.op)
      iept_pkg::OP_NEW_FLOW: begin
        flow_we    = 1'b1;
        flow_wdata = {CW'(1), in_key};
        slot_we    = 1'b1;
        slot_widx  = '0;
      end
      iept_pkg::OP_REQ_ADD: begin
        flow_we    = 1'b1;
        flow_wdata = {c_q + CW'(1), in_key};
        slot_we    = 1'b1;
        slot_widx  = c_q;
      end
      iept_pkg::OP_FLOW_KEEP: begin
        flow_we = 1'b1;
      end
      iept_pkg::OP_D_MOVE: begin
        slot_we    = 1'b1;
        slot_widx  = k_q - CW'(1);
        slot_wdata = slot_rdata;
      end
      iept_pkg::OP_D_END: begin
        flow_we    = 1'b1;
        flow_wdata = {c_q - CW'(1), in_key};
      end
      iept_pkg::OP_W_CHECK: begin
        slot_we    = !expired;
        slot_widx  = w_q;
        slot_wdata = slot_rdata;
      end
      iept_pkg::OP_W_END: begin
        flow_we    = 1'b1;
        flow_wdata = {w_q, key_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    res_flow = iept_pkg::FIDX_W'(f_q);
    if (status_q == iept_pkg::ST_DENY || status_q == iept_pkg::ST_TABLE_FULL ||
        status_q == iept_pkg::ST_IGNORED) begin
      res_flow = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == iept_pkg::OP_LOAD) begin
      kind_q <= iept_pkg::cmd_e'(s_axis_tuser);
      src_q  <= s_axis_tdata[31:0];
      dst_q  <= s_axis_tdata[63:32];
      id_q   <= s_axis_tdata[79:64];
      seq_q  <= s_axis_tdata[95:80];
    end
    if (cmd_i.op == iept_pkg::OP_F_LATCH) begin
      key_q <= flow_rdata[KW-1:0];
    end
    if (cmd_i.op == iept_pkg::OP_RESULT) begin
      m_data_q <= {2'b00, exp_q, res_flow, status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= iept_pkg::TIMEOUT_RST;
      now_q     <= '0;
      f_q       <= '0;
      fcount_q  <= '0;
      c_q       <= '0;
      k_q       <= '0;
      w_q       <= '0;
      exp_q     <= '0;
      status_q  <= iept_pkg::ST_IGNORED;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.status_we) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.op == iept_pkg::OP_RESULT) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        iept_pkg::OP_LOAD: begin
          f_q   <= '0;
          k_q   <= '0;
          exp_q <= '0;
          if (iept_pkg::cmd_e'(s_axis_tuser) == iept_pkg::CMD_TICK) begin
            now_q <= now_q + iept_pkg::STAMP_W'(1);
          end
        end
        iept_pkg::OP_F_NEXT: f_q <= f_q + FCW'(1);
        iept_pkg::OP_F_LATCH: begin
          c_q <= rd_cnt;
          k_q <= '0;
          w_q <= '0;
        end
        iept_pkg::OP_NEW_FLOW: fcount_q <= fcount_q + FCW'(1);
        iept_pkg::OP_K_NEXT, iept_pkg::OP_D_MOVE: k_q <= k_q + CW'(1);
        iept_pkg::OP_W_CHECK: begin
          k_q <= k_q + CW'(1);
          if (expired) begin
            if (exp_q != iept_pkg::EXP_MAX) begin
              exp_q <= exp_q + iept_pkg::EXP_W'(1);
            end
          end else begin
            w_q <= w_q + CW'(1);
          end
        end
        iept_pkg::OP_W_END: f_q <= f_q + FCW'(1);
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign stat_o.in_valid   = s_axis_tvalid;
  assign stat_o.in_kind    = iept_pkg::cmd_e'(s_axis_tuser);
  assign stat_o.kind       = kind_q;
  assign stat_o.f_end      = (f_q == fcount_q);
  assign stat_o.table_full = (fcount_q == FCW'(FLOWS));
  assign stat_o.hit        = (rd_id == id_q) &&
                             (((rd_snd == src_q) && (rd_dst == dst_q)) ||
                              ((rd_snd == dst_q) && (rd_dst == src_q)));
  assign stat_o.slots_full = (c_q == CW'(SLOTS));
  assign stat_o.k_end      = (k_q == c_q);
  assign stat_o.seq_hit    = (rd_seq == seq_q);
  assign stat_o.out_free   = !m_valid_q || m_axis_tready;

endmodule

@@ tb/sv/icmp_echo_pair_tracker_tb.sv @@
// Self-checking testbench for the ICMP echo pair tracker: flow table predictor and scoreboard.
module icmp_echo_pair_tracker_tb;

  localparam int NFLOW = iept_pkg::FLOWS_DEF;
  localparam int NSLOT = iept_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    iept_pkg::status_e st;
    logic [3:0]        fidx;
    logic [6:0]        expired;
  } echo_result_t;

  class echo_scoreboard;
    bit          flow_on[NFLOW];
    bit [31:0]   flow_snd[NFLOW];
    bit [31:0]   flow_dst[NFLOW];
    bit [15:0]   flow_id[NFLOW];
    bit          slot_on[NFLOW*NSLOT];
    bit [15:0]   slot_seq[NFLOW*NSLOT];
    bit [31:0]   slot_stamp[NFLOW*NSLOT];
    bit [31:0]   now_ms;
    bit [15:0]   timeout_ms = iept_pkg::TIMEOUT_RST;
    echo_result_t awaited[$];
    int          errors;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void push(iept_pkg::status_e s, int f, int e);
      echo_result_t r;
      r.st = s;
      r.fidx = f[3:0];
      r.expired = (e > 127) ? 7'd127 : e[6:0];
      awaited.insert(awaited.size(), r);
    endfunction

    function int sweep_slots();
      int cnt, b, w;
      bit [31:0] age;
      cnt = 0;
      for (int f = 0; f < NFLOW; f++) begin
        b = f * NSLOT;
        w = 0;
        for (int r = 0; r < NSLOT; r++) begin
          if (!slot_on[b+r]) continue;
          age = now_ms - slot_stamp[b+r];
          if (age >= {16'd0, timeout_ms}) begin
            cnt++;
          end else begin
            slot_on[b+w] = 1;
            slot_seq[b+w] = slot_seq[b+r];
            slot_stamp[b+w] = slot_stamp[b+r];
            w++;
          end
        end
        for (int r = w; r < NSLOT; r++) slot_on[b+r] = 0;
      end
      return cnt;
    endfunction

    function void note_input(iept_pkg::cmd_e c, bit [31:0] src, bit [31:0] dst,
                             bit [15:0] id, bit [15:0] seq);
      int f, k, b;
      bit hit;
      if (c == iept_pkg::CMD_TICK) begin
        now_ms++;
        push(iept_pkg::ST_IGNORED, 0, sweep_slots());
        return;
      end
      if (c == iept_pkg::CMD_OTHER) begin
        push(iept_pkg::ST_IGNORED, 0, 0);
        return;
      end
      hit = 0;
      for (f = 0; f < NFLOW; f++) begin
        if (!flow_on[f] || flow_id[f] != id) continue;
        if ((flow_snd[f] == src && flow_dst[f] == dst) ||
            (flow_snd[f] == dst && flow_dst[f] == src)) begin
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        if (c == iept_pkg::CMD_REPLY) begin
          push(iept_pkg::ST_DENY, 0, 0);
          return;
        end
        for (f = 0; f < NFLOW; f++) if (!flow_on[f]) break;
        if (f >= NFLOW) begin
          push(iept_pkg::ST_TABLE_FULL, 0, 0);
          return;
        end
        b = f * NSLOT;
        flow_on[f] = 1;
        flow_snd[f] = src;
        flow_dst[f] = dst;
        flow_id[f] = id;
        for (k = 0; k < NSLOT; k++) slot_on[b+k] = 0;
        slot_on[b] = 1;
        slot_seq[b] = seq;
        slot_stamp[b] = now_ms;
        push(iept_pkg::ST_NEW_FLOW, f, 0);
        return;
      end
      b = f * NSLOT;
      flow_snd[f] = src;
      flow_dst[f] = dst;
      if (c == iept_pkg::CMD_REPLY) begin
        for (k = 0; k < NSLOT; k++) begin
          if (slot_on[b+k] && slot_seq[b+k] == seq) begin
            for (int j = k; j + 1 < NSLOT; j++) begin
              slot_on[b+j] = slot_on[b+j+1];
              slot_seq[b+j] = slot_seq[b+j+1];
              slot_stamp[b+j] = slot_stamp[b+j+1];
            end
            slot_on[b+NSLOT-1] = 0;
            push(iept_pkg::ST_MATCHED, f, 0);
            return;
          end
        end
        push(iept_pkg::ST_MISMATCH, f, 0);
        return;
      end
      for (k = 0; k < NSLOT; k++) if (!slot_on[b+k]) break;
      if (k >= NSLOT) begin
        push(iept_pkg::ST_SLOTS_FULL, f, 0);
        return;
      end
      slot_on[b+k] = 1;
      slot_seq[b+k] = seq;
      slot_stamp[b+k] = now_ms;
      push(iept_pkg::ST_REQ_ADDED, f, 0);
    endfunction

    task check_result(logic [iept_pkg::OUT_DATA_W-1:0] d);
      echo_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = awaited.pop_front();
      if (d[2:0] !== e.st)
        report($sformatf("status %0d, want %0d", d[2:0], e.st));
      if (d[6:3] !== e.fidx)
        report($sformatf("flow_index %0d, want %0d", d[6:3], e.fidx));
      if (d[13:7] !== e.expired)
        report($sformatf("expired_count %0d, want %0d", d[13:7], e.expired));
    endtask
  endclass

  logic                            clk_i = 0;
  logic                            rst_ni = 0;
  logic                            cfg_we_i = 0;
  logic [iept_pkg::TIMEOUT_W-1:0]  cfg_wdata_i = '0;
  logic                            s_axis_tvalid = 0;
  logic                            s_axis_tready;
  logic [iept_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 0;
  logic [iept_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  icmp_echo_pair_tracker dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  echo_scoreboard sb = new();
  bit        stalls_on = 1;
  int        cycles;
  bit [31:0] key_src[24];
  bit [31:0] key_dst[24];
  bit [15:0] key_id[24];
  bit [15:0] key_seq[24];

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      m_axis_tready = 1;
    end
  end

  task automatic send(iept_pkg::cmd_e c, bit [31:0] src, bit [31:0] dst, bit [15:0] id,
                      bit [15:0] seq);
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = c;
    s_axis_tdata = {seq, id, dst, src};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(c, src, dst, id, seq);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_timeout(bit [15:0] v);
    drain();
    cfg_wdata_i = v;
    cfg_we_i = 1;
    sb.timeout_ms = v;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic random_packet(int nkeys);
    int r, k;
    bit [15:0] sq;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, nkeys - 1);
    sq = key_seq[k] ^ 16'($urandom_range(0, 7));
    if (r < 40)
      send(iept_pkg::CMD_REQUEST, key_src[k], key_dst[k], key_id[k], sq);
    else if (r < 70) begin
      if ($urandom_range(0, 1))
        send(iept_pkg::CMD_REPLY, key_dst[k], key_src[k], key_id[k], sq);
      else
        send(iept_pkg::CMD_REPLY, key_src[k], key_dst[k], key_id[k], sq);
    end else if (r < 88)
      send(iept_pkg::CMD_TICK, $urandom, $urandom, 16'($urandom), 16'($urandom));
    else
      send(iept_pkg::cmd_e'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom),
           16'($urandom));
  endtask

  initial begin
    bit [15:0] phase_tmo[5];
    for (int i = 0; i < 24; i++) begin
      key_src[i] = $urandom;
      key_dst[i] = $urandom;
      key_id[i] = 16'($urandom);
      key_seq[i] = 16'($urandom);
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed
    send(iept_pkg::CMD_OTHER, '1, '1, '1, '1);
    send(iept_pkg::CMD_REPLY, '0, '0, '0, '0);
    send(iept_pkg::CMD_REQUEST, '0, '0, '0, '0);
    send(iept_pkg::CMD_REQUEST, '1, '1, '1, '1);
    send(iept_pkg::CMD_REQUEST, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd5);
    send(iept_pkg::CMD_REQUEST, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd7);
    send(iept_pkg::CMD_REQUEST, 32'h0a000002, 32'h0a000001, 16'h1234, 16'd5);
    send(iept_pkg::CMD_REQUEST, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd9);
    send(iept_pkg::CMD_REQUEST, 32'h0a000003, 32'h0a000002, 16'h1234, 16'd11);
    send(iept_pkg::CMD_REQUEST, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd11);
    send(iept_pkg::CMD_REPLY, 32'h0a000002, 32'h0a000001, 16'h1234, 16'd5);
    send(iept_pkg::CMD_REPLY, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd99);
    send(iept_pkg::CMD_REPLY, 32'h0a000001, 32'h0a000002, 16'h4321, 16'd7);
    send(iept_pkg::CMD_REQUEST, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd13);
    send(iept_pkg::CMD_TICK, '0, '0, '0, '0);
    send(iept_pkg::CMD_TICK, '1, '1, '1, '1);
    set_timeout(16'd0);
    send(iept_pkg::CMD_TICK, '0, '0, '0, '0);
    send(iept_pkg::CMD_REPLY, 32'h0a000001, 32'h0a000002, 16'h1234, 16'd7);
    set_timeout(16'd1000);

    phase_tmo[0] = 16'd1;
    phase_tmo[1] = 16'd3;
    phase_tmo[2] = 16'hffff;
    phase_tmo[3] = 16'($urandom_range(2, 20));
    phase_tmo[4] = 16'd2;
    for (int p = 0; p < 5; p++) begin
      set_timeout(phase_tmo[p]);
      if (p == 4) stalls_on = 0;
      for (int i = 0; i < 160; i++) begin
        if (p == 1 && i == 80) drain();
        random_packet(p < 2 ? 12 : 24);
      end
    end

    drain();
    repeat (300) @(negedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
